// File: hdl/sobel_gradient_magnitude_3x3_unit_macros.svh
// Assertion macros shared by the checker of the Sobel gradient unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SOBEL_GRADIENT_MAGNITUDE_3X3_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_3X3_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SGM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgm assertion failed");

`endif

// File: hdl/sgm_pkg.sv
// Types and constants of the Sobel gradient unit.
// Depends on nothing; used by every module of the block.
package sgm_pkg;

   localparam int PIXEL_W      = 8;
   localparam int GRAD_W       = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int ROW_OUT_W    = 12;
   localparam int COL_OUT_W    = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam int SUM_W      = 17;
   localparam int ROOT_W     = 18;
   localparam int SQRT_STEPS = 9;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [8:0] window_type;

   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_core_type;

endpackage

// File: hdl/sgm_interfaces.sv
// Valid/ready channel interfaces for the pixel input and the gradient result.
// Depends on sgm_pkg.
interface sgm_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface sgm_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [7:0]                    vertical_gradient;
   logic [7:0]                    horizontal_gradient;
   logic [7:0]                    magnitude;
   logic [sgm_pkg::ROW_OUT_W-1:0] centre_row;
   logic [sgm_pkg::COL_OUT_W-1:0] centre_col;

   modport source (output valid, output vertical_gradient, output horizontal_gradient,
                   output magnitude, output centre_row, output centre_col, input ready);
   modport sink (input valid, input vertical_gradient, input horizontal_gradient,
                 input magnitude, input centre_row, input centre_col, output ready);
endinterface

// File: hdl/sobel_gradient_magnitude_3x3_unit.sv
// Top level of the 3x3 Sobel gradient and magnitude unit.
// Depends on sgm_pkg, sgm_interfaces, sgm_window, sgm_gradient and sgm_sqrt_cell.
//
// Pixels arrive on req_ch in raster order, one per transaction. For every
// interior pixel of the frame one transaction leaves on rsp_ch carrying the
// clamped vertical and horizontal gradients, the floor square root of the sum
// of their squares (saturated to 255) and the centre row and column. Border
// pixels give no result.
// After the transaction of the window's bottom-right pixel a result passes the
// line store read and window registers, the gradient and square registers, the
// nine square root cells and the output register. One pixel is taken per cycle
// unless rsp_ch stalls; the nine-cell root chain is fully pipelined and each
// line store is read and written in the same cycle. The csr port sets image
// width and height; a write restarts the frame at row 0, column 0, and the user
// makes it only while the unit holds no transaction, which the unit does not
// enforce. Reset clears the position counters, the window and all valid flags,
// and restores 512 by 512 (limited to the maximum size). When rsp_ch stalls
// with a result waiting, the whole pipeline holds and req_ch.ready is low.
module sobel_gradient_magnitude_3x3_unit #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   sgm_req_if.sink                             req_ch,
   sgm_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WCNT  = $clog2(MAX_WIDTH + 1);
   localparam int HCNT  = $clog2(MAX_HEIGHT + 1);
   localparam int POS_W = RW + CW;
   localparam int TAG_W = 2 * sgm_pkg::GRAD_W + POS_W;
   localparam int WIDTH_RESET  = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
   localparam int HEIGHT_RESET = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

   logic                               advance;
   logic                               accept;
   logic                               restart;
   logic [sgm_pkg::CFG_WIDTH_W-1:0]    raw_width;
   logic [sgm_pkg::CFG_HEIGHT_W-1:0]   raw_height;
   logic [WCNT-1:0]                    width_ff, width_in;
   logic [HCNT-1:0]                    height_ff, height_in;

   logic                               win_valid;
   sgm_pkg::window_type                win_pixels;
   logic [POS_W-1:0]                   win_pos;

   sgm_pkg::sqrt_core_type             core_chain [sgm_pkg::SQRT_STEPS+1];
   logic [TAG_W-1:0]                   tag_chain [sgm_pkg::SQRT_STEPS+1];

   logic                               rsp_valid_ff;
   logic [sgm_pkg::GRAD_W-1:0]         mag_in;
   logic [sgm_pkg::GRAD_W-1:0]         mag_ff;
   logic [TAG_W-1:0]                   rsp_tag_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;
   assign restart      = csr_we && (csr_index == sgm_pkg::CSR_IMAGE_WIDTH ||
                                    csr_index == sgm_pkg::CSR_IMAGE_HEIGHT);

   always_comb begin
      raw_width  = csr_data[sgm_pkg::CFG_WIDTH_W-1:0];
      raw_height = csr_data[sgm_pkg::CFG_HEIGHT_W-1:0];
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_we && csr_index == sgm_pkg::CSR_IMAGE_WIDTH) begin
         if (32'(raw_width) < 32'd3) begin
            width_in = WCNT'(3);
         end else if (32'(raw_width) > 32'(MAX_WIDTH)) begin
            width_in = WCNT'(MAX_WIDTH);
         end else begin
            width_in = WCNT'(raw_width);
         end
      end
      if (csr_we && csr_index == sgm_pkg::CSR_IMAGE_HEIGHT) begin
         if (32'(raw_height) < 32'd3) begin
            height_in = HCNT'(3);
         end else if (32'(raw_height) > 32'(MAX_HEIGHT)) begin
            height_in = HCNT'(MAX_HEIGHT);
         end else begin
            height_in = HCNT'(raw_height);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WCNT'(WIDTH_RESET);
         height_ff <= HCNT'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   sgm_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .accept     (accept),
      .restart    (restart),
      .pixel      (req_ch.pixel),
      .eff_width  (width_ff),
      .eff_height (height_ff),
      .out_valid  (win_valid),
      .window     (win_pixels),
      .pos        (win_pos)
   );

   sgm_gradient #(
      .POS_W (POS_W)
   ) u_gradient (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (win_valid),
      .window   (win_pixels),
      .pos      (win_pos),
      .core     (core_chain[0]),
      .tag      (tag_chain[0])
   );

   for (genvar g = 0; g < sgm_pkg::SQRT_STEPS; g++) begin : g_root
      sgm_sqrt_cell #(
         .STEP  (g),
         .TAG_W (TAG_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .core_in  (core_chain[g]),
         .tag_in   (tag_chain[g]),
         .core_out (core_chain[g+1]),
         .tag_out  (tag_chain[g+1])
      );
   end

   always_comb begin
      if (core_chain[sgm_pkg::SQRT_STEPS].root > sgm_pkg::ROOT_W'(255)) begin
         mag_in = '1;
      end else begin
         mag_in = core_chain[sgm_pkg::SQRT_STEPS].root[sgm_pkg::GRAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= core_chain[sgm_pkg::SQRT_STEPS].valid;
      end
      if (advance) begin
         mag_ff     <= mag_in;
         rsp_tag_ff <= tag_chain[sgm_pkg::SQRT_STEPS];
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.magnitude           = mag_ff;
   assign rsp_ch.vertical_gradient   = rsp_tag_ff[TAG_W-1 -: sgm_pkg::GRAD_W];
   assign rsp_ch.horizontal_gradient = rsp_tag_ff[POS_W +: sgm_pkg::GRAD_W];
   assign rsp_ch.centre_row          = sgm_pkg::ROW_OUT_W'(rsp_tag_ff[CW +: RW]);
   assign rsp_ch.centre_col          = sgm_pkg::COL_OUT_W'(rsp_tag_ff[CW-1:0]);

endmodule

// File: hdl/sgm_window.sv
// Raster position counters, the two line stores and the 3x3 window.
// Depends on sgm_pkg.
module sgm_window #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int WCNT = $clog2(MAX_WIDTH + 1),
   localparam int HCNT = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   accept,
   input  logic                   restart,
   input  sgm_pkg::pixel_type     pixel,
   input  logic [WCNT-1:0]        eff_width,
   input  logic [HCNT-1:0]        eff_height,
   output logic                   out_valid,
   output sgm_pkg::window_type    window,
   output logic [RW+CW-1:0]       pos
);

   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [WCNT-1:0]     col_next;
   logic [HCNT-1:0]     row_next;

   sgm_pkg::pixel_type  upper_store_ff [MAX_WIDTH];
   sgm_pkg::pixel_type  middle_store_ff [MAX_WIDTH];
   sgm_pkg::pixel_type  top_rd_ff;
   sgm_pkg::pixel_type  mid_rd_ff;

   logic                s1_valid_ff;
   sgm_pkg::pixel_type  s1_pixel_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [RW-1:0]       s1_row_ff;

   logic                s2_valid_ff, s2_valid_in;
   sgm_pkg::window_type window_ff, window_in;
   logic [RW+CW-1:0]    pos_ff, pos_in;

   always_comb begin
      col_next = WCNT'(col_ff) + WCNT'(1);
      row_next = HCNT'(row_ff) + HCNT'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_next >= eff_width) begin
            col_in = '0;
            if (row_next >= eff_height) begin
               row_in = '0;
            end else begin
               row_in = RW'(row_next);
            end
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The stores are read when a pixel is taken and written from the s1 registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= upper_store_ff[col_ff];
         mid_rd_ff <= middle_store_ff[col_ff];
      end
      if (advance && s1_valid_ff) begin
         upper_store_ff[s1_col_ff]  <= mid_rd_ff;
         middle_store_ff[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_pixel_ff <= pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   always_comb begin
      window_in = window_ff;
      s2_valid_in = s1_valid_ff && (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));
      pos_in = {s1_row_ff - RW'(1), s1_col_ff - CW'(1)};
      if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            window_in[k*3]     = window_ff[k*3 + 1];
            window_in[k*3 + 1] = window_ff[k*3 + 2];
         end
         window_in[2] = top_rd_ff;
         window_in[5] = mid_rd_ff;
         window_in[8] = s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
         window_ff   <= window_in;
      end
      if (advance) begin
         pos_ff <= pos_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign window    = window_ff;
   assign pos       = pos_ff;

endmodule

// File: hdl/sgm_gradient.sv
// Clamped Sobel gradients of the window and the sum of their squares.
// Depends on sgm_pkg.
module sgm_gradient #(
   parameter int POS_W = 22,
   localparam int TAG_W = 2 * sgm_pkg::GRAD_W + POS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  sgm_pkg::window_type    window,
   input  logic [POS_W-1:0]       pos,
   output sgm_pkg::sqrt_core_type core,
   output logic [TAG_W-1:0]       tag
);

   function automatic logic [sgm_pkg::GRAD_W-1:0] clamp_grad(
      input logic [9:0] plus_sum,
      input logic [9:0] minus_sum
   );
      logic [11:0] diff;
      diff = {2'b00, plus_sum} - {2'b00, minus_sum};
      if (diff[11]) begin
         clamp_grad = '0;
      end else if (|diff[10:8]) begin
         clamp_grad = '1;
      end else begin
         clamp_grad = diff[7:0];
      end
   endfunction

   function automatic logic [9:0] weighted(
      input sgm_pkg::pixel_type a,
      input sgm_pkg::pixel_type b,
      input sgm_pkg::pixel_type c
   );
      weighted = 10'(a) + {1'b0, b, 1'b0} + 10'(c);
   endfunction

   logic                        a_valid_ff;
   logic [sgm_pkg::GRAD_W-1:0]  vg_ff, vg_in;
   logic [sgm_pkg::GRAD_W-1:0]  hg_ff, hg_in;
   logic [POS_W-1:0]            a_pos_ff;
   logic [15:0]                 v_sq, h_sq;
   sgm_pkg::sqrt_core_type      core_ff, core_in;
   logic [TAG_W-1:0]            tag_ff;

   always_comb begin
      vg_in = clamp_grad(weighted(window[6], window[7], window[8]),
                         weighted(window[0], window[1], window[2]));
      hg_in = clamp_grad(weighted(window[2], window[5], window[8]),
                         weighted(window[0], window[3], window[6]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
      if (advance) begin
         vg_ff    <= vg_in;
         hg_ff    <= hg_in;
         a_pos_ff <= pos;
      end
   end

   always_comb begin
      v_sq = vg_ff * vg_ff;
      h_sq = hg_ff * hg_ff;
      core_in.valid = a_valid_ff;
      core_in.rem   = sgm_pkg::SUM_W'(v_sq) + sgm_pkg::SUM_W'(h_sq);
      core_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_ff <= '0;
      end else if (advance) begin
         core_ff <= core_in;
      end
      if (advance) begin
         tag_ff <= {vg_ff, hg_ff, a_pos_ff};
      end
   end

   assign core = core_ff;
   assign tag  = tag_ff;

endmodule

// File: hdl/sgm_sqrt_cell.sv
// One step of the bitwise integer square root; the cells form a chain.
// Depends on sgm_pkg.
module sgm_sqrt_cell #(
   parameter int STEP = 0,
   parameter int TAG_W = 38
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sgm_pkg::sqrt_core_type core_in,
   input  logic [TAG_W-1:0]       tag_in,
   output sgm_pkg::sqrt_core_type core_out,
   output logic [TAG_W-1:0]       tag_out
);

   localparam logic [sgm_pkg::ROOT_W-1:0] BIT =
      sgm_pkg::ROOT_W'(1) << (2 * (sgm_pkg::SQRT_STEPS - 1 - STEP));

   logic [sgm_pkg::ROOT_W:0] trial;
   sgm_pkg::sqrt_core_type   core_ff, core_nx_in;
   logic [TAG_W-1:0]         tag_ff;

   always_comb begin
      trial = {1'b0, core_in.root} + {1'b0, BIT};
      core_nx_in.valid = core_in.valid;
      if ({2'b00, core_in.rem} >= trial) begin
         core_nx_in.rem  = core_in.rem - sgm_pkg::SUM_W'(trial);
         core_nx_in.root = (core_in.root >> 1) + BIT;
      end else begin
         core_nx_in.rem  = core_in.rem;
         core_nx_in.root = core_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_ff <= '0;
      end else if (advance) begin
         core_ff <= core_nx_in;
      end
      if (advance) begin
         tag_ff <= tag_in;
      end
   end

   assign core_out = core_ff;
   assign tag_out  = tag_ff;

endmodule

// File: hdl/sgm_checker.sv
// Port-level checks of the Sobel gradient unit and the bind that attaches them.
// Depends on sgm_pkg and sobel_gradient_magnitude_3x3_unit_macros.svh.
`include "sobel_gradient_magnitude_3x3_unit_macros.svh"

module sgm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [7:0]                    vertical_gradient,
   input logic [7:0]                    horizontal_gradient,
   input logic [7:0]                    magnitude,
   input logic [sgm_pkg::ROW_OUT_W-1:0] centre_row,
   input logic [sgm_pkg::COL_OUT_W-1:0] centre_col
);

   `SGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(magnitude) && $stable(vertical_gradient) &&
      $stable(horizontal_gradient) && $stable(centre_row) && $stable(centre_col))

   `SGM_ASSERT_NOW(a_mag_floor_root, clock, reset, rsp_valid,
      (18'(magnitude) * 18'(magnitude) <=
       18'(vertical_gradient) * 18'(vertical_gradient) +
       18'(horizontal_gradient) * 18'(horizontal_gradient)) &&
      (magnitude == 8'hFF ||
       (18'(magnitude) + 18'd1) * (18'(magnitude) + 18'd1) >
       18'(vertical_gradient) * 18'(vertical_gradient) +
       18'(horizontal_gradient) * 18'(horizontal_gradient)))

   `SGM_ASSERT_NOW(a_interior_only, clock, reset, rsp_valid,
      centre_row != '0 && centre_col != '0)

   `SGM_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   `SGM_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind sobel_gradient_magnitude_3x3_unit sgm_checker u_sgm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .vertical_gradient   (rsp_ch.vertical_gradient),
   .horizontal_gradient (rsp_ch.horizontal_gradient),
   .magnitude           (rsp_ch.magnitude),
   .centre_row          (rsp_ch.centre_row),
   .centre_col          (rsp_ch.centre_col)
);
